/* rtl/eff_pkg.sv */
// Package for the Euler face flux block: payload types, pipeline sizing, saturation.
package eff_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;

  // Word width is capped by the 32-bit fields; fraction bits held in [1, WB-1].
  localparam int WB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int FB = (FRACTION_BITS < 1) ? 1 :
                      ((FRACTION_BITS > WB - 1) ? WB - 1 : FRACTION_BITS);

  localparam int LANES     = 4;           // mx, my, mz, energy share one divisor
  localparam int LANE_E    = 3;
  localparam int DIV_STEPS = 32 + FB;     // quotient bits, one per stage
  localparam int SH_W      = 64 - FB;     // width of a product after the fraction shift
  localparam int LATENCY   = DIV_STEPS + 6;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (WB - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef struct packed {
    logic [30:0]        density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] energy_density;
    logic signed [31:0] pressure;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mass_flux;
    logic signed [31:0] momentum_flux_x;
    logic signed [31:0] momentum_flux_y;
    logic signed [31:0] momentum_flux_z;
    logic signed [31:0] energy_flux;
    logic [30:0]        speed_squared;
    logic signed [31:0] internal_energy;
    logic               zero_density;
    logic               saturated;
  } out_t;

  // Operands that ride along with the divider.
  typedef struct packed {
    logic [30:0]                   density;
    logic                          zero;
    logic [LANES-1:0]              neg;
    logic [2:0][31:0]              mom;
    logic signed [31:0]            energy;
    logic signed [31:0]            pres;
    logic [2:0][31:0]              nrm;
  } side_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               c;
  } sat_t;

  function automatic sat_t sat_w(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.v = SAT_HI[31:0];
      r.c = 1'b1;
    end else if (v < SAT_LO) begin
      r.v = SAT_LO[31:0];
      r.c = 1'b1;
    end else begin
      r.v = v[31:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/eff_div.sv */
// Pipelined restoring divider: four numerators over one divisor, one quotient bit per stage.
module eff_div import eff_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [LANES-1:0][31:0]              in_num,
  input  side_t                               in_side,
  output logic                                out_valid,
  output logic [LANES-1:0][DIV_STEPS-1:0]     out_quot,
  output side_t                               out_side
);

  logic                              vld_r  [DIV_STEPS];
  side_t                             side_r [DIV_STEPS];
  logic [LANES-1:0][31:0]            num_r  [DIV_STEPS];
  logic [LANES-1:0][30:0]            rem_r  [DIV_STEPS];
  logic [LANES-1:0][DIV_STEPS-1:0]   quo_r  [DIV_STEPS];

  genvar g, l;
  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_stage
      localparam int J = DIV_STEPS - 1 - g;   // dividend bit consumed here
      logic                            v_in;
      side_t                           s_in;
      logic [LANES-1:0][31:0]          n_in;
      logic [LANES-1:0][30:0]          r_in;
      logic [LANES-1:0][DIV_STEPS-1:0] q_in;
      logic [LANES-1:0]                dbit;
      logic [LANES-1:0][30:0]          rem_nxt;
      logic [LANES-1:0][DIV_STEPS-1:0] quo_nxt;

      if (g == 0) begin : g_first
        assign v_in = in_valid;
        assign s_in = in_side;
        assign n_in = in_num;
        assign r_in = '0;
        assign q_in = '0;
      end else begin : g_next
        assign v_in = vld_r[g-1];
        assign s_in = side_r[g-1];
        assign n_in = num_r[g-1];
        assign r_in = rem_r[g-1];
        assign q_in = quo_r[g-1];
      end

      for (l = 0; l < LANES; l++) begin : g_lane
        if (J >= FB) begin : g_bit
          assign dbit[l] = n_in[l][J-FB];
        end else begin : g_zero
          assign dbit[l] = 1'b0;
        end
      end

      always_comb begin
        logic [31:0] trial;
        for (int k = 0; k < LANES; k++) begin
          trial = {r_in[k], dbit[k]};
          if (trial >= {1'b0, s_in.density}) begin
            rem_nxt[k] = 31'(trial - {1'b0, s_in.density});
            quo_nxt[k] = {q_in[k][DIV_STEPS-2:0], 1'b1};
          end else begin
            rem_nxt[k] = trial[30:0];
            quo_nxt[k] = {q_in[k][DIV_STEPS-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else begin
          vld_r[g] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        side_r[g] <= s_in;
        num_r[g]  <= n_in;
        rem_r[g]  <= rem_nxt;
        quo_r[g]  <= quo_nxt;
      end
    end
  endgenerate

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quot  = quo_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      if (rem_r[DIV_STEPS-1][k] >= out_side.density) begin
        rem_ok = 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_side.zero |-> rem_ok)
    else $error("divider remainder not below divisor");
`endif

endmodule

/* rtl/euler_face_flux.sv */
// Top level of the Euler face flux block: pipelined normal-flux evaluation for one face per cycle.
//
// Usage:
//   Drive one cell state, pressure and face normal on in_item and pulse start.
//   The item is taken at every rising edge where start is high and busy is low;
//   busy stays low, so a new item may be given in every cycle.
//   Each result appears on out_item for exactly one cycle with out_valid high.
//   Throughput is one item per cycle.
//   The divider gives one quotient bit per pipeline stage for the 48-bit scaled
//   numerators at Q16.16, four lanes (three momenta, energy) side by side.
//   An input register (magnitudes and signs) feeds the divider. After it come a
//   sign/saturate stage, two multiply stages each followed by an add/saturate
//   stage, the last one writing the output register.
//   Reset (synchronous, rst_n low) clears all valid bits; items in flight are
//   dropped and no result appears until a new item arrives.
//   The receiver cannot stall: out_valid is a strobe and must be taken when it comes.
//   A zero density gives zero_density = 1 with every other field zero.
module euler_face_flux import eff_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // ---------------- prep: magnitudes and signs for the divider ----------------
  logic                   prep_vld_r;
  logic [LANES-1:0][31:0] prep_num_r;
  side_t                  prep_side_r;
  logic [LANES-1:0][31:0] prep_num_nxt;
  side_t                  prep_side_nxt;

  always_comb begin
    logic signed [31:0] a [LANES];
    a[0] = in_item.momentum_x;
    a[1] = in_item.momentum_y;
    a[2] = in_item.momentum_z;
    a[LANE_E] = in_item.energy_density;
    for (int k = 0; k < LANES; k++) begin
      prep_side_nxt.neg[k] = a[k][31];
      prep_num_nxt[k] = a[k][31] ? 32'(-a[k]) : a[k];
    end
    prep_side_nxt.density = in_item.density;
    prep_side_nxt.zero    = (in_item.density == '0);
    prep_side_nxt.mom[0]  = in_item.momentum_x;
    prep_side_nxt.mom[1]  = in_item.momentum_y;
    prep_side_nxt.mom[2]  = in_item.momentum_z;
    prep_side_nxt.energy  = in_item.energy_density;
    prep_side_nxt.pres    = in_item.pressure;
    prep_side_nxt.nrm[0]  = in_item.normal_x;
    prep_side_nxt.nrm[1]  = in_item.normal_y;
    prep_side_nxt.nrm[2]  = in_item.normal_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else begin
      prep_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    prep_num_r  <= prep_num_nxt;
    prep_side_r <= prep_side_nxt;
  end

  // ---------------- divider ----------------
  logic                              dv_vld;
  logic [LANES-1:0][DIV_STEPS-1:0]   dv_quot;
  side_t                             dv_side;

  eff_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_vld_r),
    .in_num    (prep_num_r),
    .in_side   (prep_side_r),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ---------------- fix: apply sign, saturate velocities and E/rho ----------------
  logic                     fx_vld_r;
  logic signed [31:0]       fx_u_r [3];
  logic signed [31:0]       fx_ediv_r;
  logic                     fx_sat_r;
  side_t                    fx_side_r;
  logic signed [31:0]       fx_u_nxt [3];
  logic signed [31:0]       fx_ediv_nxt;
  logic                     fx_sat_nxt;

  always_comb begin
    logic signed [63:0] mag;
    sat_t s;
    fx_sat_nxt  = 1'b0;
    fx_ediv_nxt = '0;
    for (int k = 0; k < LANES; k++) begin
      mag = 64'(dv_quot[k]);
      s = sat_w(dv_side.neg[k] ? -mag : mag);
      fx_sat_nxt = fx_sat_nxt | s.c;
      if (k == LANE_E) begin
        fx_ediv_nxt = s.v;
      end else begin
        fx_u_nxt[k] = s.v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_vld_r <= 1'b0;
    end else begin
      fx_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    fx_u_r    <= fx_u_nxt;
    fx_ediv_r <= fx_ediv_nxt;
    fx_sat_r  <= fx_sat_nxt;
    fx_side_r <= dv_side;
  end

  // ---------------- m1: u.n, u.u and p*n products ----------------
  logic                     m1_vld_r;
  logic signed [SH_W-1:0]   m1_un_r [3];
  logic signed [SH_W-1:0]   m1_uu_r [3];
  logic signed [SH_W-1:0]   m1_pn_r [3];
  logic signed [31:0]       m1_ediv_r;
  logic                     m1_sat_r;
  side_t                    m1_side_r;
  logic signed [SH_W-1:0]   m1_un_nxt [3];
  logic signed [SH_W-1:0]   m1_uu_nxt [3];
  logic signed [SH_W-1:0]   m1_pn_nxt [3];

  always_comb begin
    logic signed [63:0] pr;
    for (int k = 0; k < 3; k++) begin
      pr = fx_u_r[k] * $signed(fx_side_r.nrm[k]);
      m1_un_nxt[k] = SH_W'(pr >>> FB);
      pr = fx_u_r[k] * fx_u_r[k];
      m1_uu_nxt[k] = SH_W'(pr >>> FB);
      pr = fx_side_r.pres * $signed(fx_side_r.nrm[k]);
      m1_pn_nxt[k] = SH_W'(pr >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= fx_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_un_r   <= m1_un_nxt;
    m1_uu_r   <= m1_uu_nxt;
    m1_pn_r   <= m1_pn_nxt;
    m1_ediv_r <= fx_ediv_r;
    m1_sat_r  <= fx_sat_r;
    m1_side_r <= fx_side_r;
  end

  // ---------------- a1: normal velocity and squared speed ----------------
  logic                     a1_vld_r;
  logic signed [31:0]       a1_vn_r;
  logic signed [31:0]       a1_q_r;
  logic signed [SH_W-1:0]   a1_pn_r [3];
  logic signed [31:0]       a1_ediv_r;
  logic                     a1_sat_r;
  side_t                    a1_side_r;
  sat_t                     a1_vn_nxt;
  sat_t                     a1_q_nxt;

  always_comb begin
    logic signed [SH_W+1:0] svn;
    logic signed [SH_W+1:0] sq;
    svn = (SH_W+2)'(m1_un_r[0]) + (SH_W+2)'(m1_un_r[1]) + (SH_W+2)'(m1_un_r[2]);
    sq  = (SH_W+2)'(m1_uu_r[0]) + (SH_W+2)'(m1_uu_r[1]) + (SH_W+2)'(m1_uu_r[2]);
    a1_vn_nxt = sat_w(64'(svn));
    a1_q_nxt  = sat_w(64'(sq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_vn_r   <= a1_vn_nxt.v;
    a1_q_r    <= a1_q_nxt.v;
    a1_pn_r   <= m1_pn_r;
    a1_ediv_r <= m1_ediv_r;
    a1_sat_r  <= m1_sat_r | a1_vn_nxt.c | a1_q_nxt.c;
    a1_side_r <= m1_side_r;
  end

  // ---------------- m2: products with the normal velocity ----------------
  logic                     m2_vld_r;
  logic signed [SH_W-1:0]   m2_rv_r;
  logic signed [SH_W-1:0]   m2_mv_r [3];
  logic signed [SH_W-1:0]   m2_ev_r;
  logic signed [SH_W-1:0]   m2_pv_r;
  logic signed [SH_W-1:0]   m2_pn_r [3];
  logic signed [31:0]       m2_q_r;
  logic signed [31:0]       m2_ediv_r;
  logic                     m2_sat_r;
  logic                     m2_zero_r;
  logic signed [SH_W-1:0]   m2_rv_nxt;
  logic signed [SH_W-1:0]   m2_mv_nxt [3];
  logic signed [SH_W-1:0]   m2_ev_nxt;
  logic signed [SH_W-1:0]   m2_pv_nxt;

  always_comb begin
    logic signed [63:0] pr;
    pr = $signed({1'b0, a1_side_r.density}) * a1_vn_r;
    m2_rv_nxt = SH_W'(pr >>> FB);
    for (int k = 0; k < 3; k++) begin
      pr = $signed(a1_side_r.mom[k]) * a1_vn_r;
      m2_mv_nxt[k] = SH_W'(pr >>> FB);
    end
    pr = a1_side_r.energy * a1_vn_r;
    m2_ev_nxt = SH_W'(pr >>> FB);
    pr = a1_side_r.pres * a1_vn_r;
    m2_pv_nxt = SH_W'(pr >>> FB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= a1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_rv_r   <= m2_rv_nxt;
    m2_mv_r   <= m2_mv_nxt;
    m2_ev_r   <= m2_ev_nxt;
    m2_pv_r   <= m2_pv_nxt;
    m2_pn_r   <= a1_pn_r;
    m2_q_r    <= a1_q_r;
    m2_ediv_r <= a1_ediv_r;
    m2_sat_r  <= a1_sat_r;
    m2_zero_r <= a1_side_r.zero;
  end

  // ---------------- a2: final sums, saturation, zero-density override ----------------
  logic out_vld_r;
  out_t out_r;
  out_t out_nxt;

  always_comb begin
    sat_t s_mass, s_e, s_ie;
    sat_t s_mf [3];
    logic signed [SH_W:0] sum;
    logic signed [32:0]   ie;
    s_mass = sat_w(64'(m2_rv_r));
    for (int k = 0; k < 3; k++) begin
      sum = (SH_W+1)'(m2_mv_r[k]) + (SH_W+1)'(m2_pn_r[k]);
      s_mf[k] = sat_w(64'(sum));
    end
    sum = (SH_W+1)'(m2_ev_r) + (SH_W+1)'(m2_pv_r);
    s_e = sat_w(64'(sum));
    ie = 33'(m2_ediv_r) - 33'(m2_q_r >>> 1);
    s_ie = sat_w(64'(ie));

    out_nxt.mass_flux       = s_mass.v;
    out_nxt.momentum_flux_x = s_mf[0].v;
    out_nxt.momentum_flux_y = s_mf[1].v;
    out_nxt.momentum_flux_z = s_mf[2].v;
    out_nxt.energy_flux     = s_e.v;
    out_nxt.speed_squared   = m2_q_r[30:0];
    out_nxt.internal_energy = s_ie.v;
    out_nxt.zero_density    = 1'b0;
    out_nxt.saturated       = m2_sat_r | s_mass.c | s_mf[0].c | s_mf[1].c | s_mf[2].c
                              | s_e.c | s_ie.c;
    if (m2_zero_r) begin
      out_nxt = '0;
      out_nxt.zero_density = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LATENCY))
    else $error("result without an item taken LATENCY cycles earlier");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_density |->
      out_item.mass_flux == '0 && out_item.energy_flux == '0 &&
      out_item.speed_squared == '0 && out_item.internal_energy == '0 &&
      !out_item.saturated)
    else $error("zero density result carries nonzero fields");
`endif

endmodule
